// ----- hw/rtl/trd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report decoder package
// Shared types, codes and constants of the touch report decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Bytes kept for one report (the longer of the two formats).
  localparam int STORE_DEPTH = 9;

  localparam logic [3:0] LEN_A = 4'd8;
  localparam logic [3:0] LEN_B = 4'd9;

  localparam logic [7:0] MAX_POINTS = 8'd5;
  localparam logic [7:0] TYPE_TOUCH = 8'hFF;
  localparam logic [15:0] CSUM_SEED = 16'h0055;

  typedef logic [STORE_DEPTH-1:0][7:0] report_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_A    = 2'd1,
    KIND_B    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_KIND     = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_INVERT_X = 3'd3,
    REG_INVERT_Y = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_FRESH  = 2'd0,
    ST_BUS    = 2'd1,
    ST_CSUM   = 2'd2,
    ST_NOCTRL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EV_NOCTRL = 2'd0,
    EV_BUS    = 2'd1,
    EV_DEC_A  = 2'd2,
    EV_DEC_B  = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    VD_RELEASE = 2'd0,
    VD_PRESS   = 2'd1,
    VD_CSUM    = 2'd2
  } verdict_e;

  typedef struct packed {
    logic valid;
    ev_e  code;
  } ev_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [11:0] x;
    logic [11:0] y;
  } dec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/trd_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report decoder: byte capture
// Collects reply bytes into the report store and posts one event per result.
// ----------------------------------------------------------------------------
module trd_capture (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            op_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic [1:0]      kind_i,
  input  wire logic            adv_i,
  output trd_pkg::ev_t         ev_o,
  output trd_pkg::report_t     store_o
);

  logic [3:0]       idx_q, idx_d, idx_inc, len;
  trd_pkg::ev_t     ev_q, ev_d;
  trd_pkg::report_t store_q;
  logic             accept, ctrl_ok;

  // The store must not change while a decode is waiting for the output side.
  assign in_ready_o = !ev_q.valid || adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ctrl_ok    = (kind_i == trd_pkg::KIND_A) || (kind_i == trd_pkg::KIND_B);
  assign idx_inc    = idx_q + 4'd1;
  assign len        = (kind_i == trd_pkg::KIND_A) ? trd_pkg::LEN_A : trd_pkg::LEN_B;

  always_comb begin
    idx_d = idx_q;
    ev_d  = ev_q;
    if (adv_i) begin
      ev_d.valid = 1'b0;
    end
    if (accept) begin
      if (!ctrl_ok) begin
        idx_d      = '0;
        ev_d.valid = 1'b1;
        ev_d.code  = trd_pkg::EV_NOCTRL;
      end else if (op_i) begin
        idx_d      = '0;
        ev_d.valid = 1'b1;
        ev_d.code  = trd_pkg::EV_BUS;
      end else if (idx_inc >= len) begin
        idx_d      = '0;
        ev_d.valid = 1'b1;
        ev_d.code  = (kind_i == trd_pkg::KIND_A) ? trd_pkg::EV_DEC_A : trd_pkg::EV_DEC_B;
      end else begin
        idx_d = idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ev_q  <= '0;
    end else begin
      idx_q <= idx_d;
      ev_q  <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ctrl_ok && !op_i && (idx_q < 4'(trd_pkg::STORE_DEPTH))) begin
      store_q[idx_q] <= data_byte_i;
    end
  end

  assign ev_o    = ev_q;
  assign store_o = store_q;

endmodule
`default_nettype wire

// ----- hw/rtl/trd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report decoder: report decode
// Classifies a stored report and extracts its raw coordinates.
// ----------------------------------------------------------------------------
module trd_decode (
  input  wire trd_pkg::report_t store_i,
  input  wire logic             fmt_b_i,
  output trd_pkg::dec_t         dec_o
);

  logic [7:0]  fingers, keys, count;
  logic [15:0] sum;
  logic        csum_ok;

  assign fingers = {4'd0, store_i[3][3:0]};
  assign keys    = {4'd0, store_i[3][7:4]};
  assign count   = fingers + keys;
  assign sum     = trd_pkg::CSUM_SEED + {8'd0, store_i[4]} + {8'd0, store_i[5]}
                 + {8'd0, store_i[6]} + {8'd0, store_i[7]} + {8'd0, store_i[8]};
  assign csum_ok = (sum == {store_i[1], store_i[0]});

  always_comb begin
    dec_o.verdict = trd_pkg::VD_RELEASE;
    if (!fmt_b_i) begin
      dec_o.x = {store_i[2][3:0], store_i[3]};
      dec_o.y = {store_i[4][3:0], store_i[5]};
      if ((store_i[1] != 8'd0) && (store_i[1] <= trd_pkg::MAX_POINTS)) begin
        dec_o.verdict = trd_pkg::VD_PRESS;
      end
    end else begin
      dec_o.x = {store_i[7][3:0], store_i[4]};
      dec_o.y = {store_i[7][7:4], store_i[5]};
      if ((store_i[2] != trd_pkg::TYPE_TOUCH) || (fingers == 8'd0)
          || (count > trd_pkg::MAX_POINTS)) begin
        dec_o.verdict = trd_pkg::VD_RELEASE;
      end else if ((count == 8'd1) && !csum_ok) begin
        // A single contact carries a checksum over the contact bytes.
        dec_o.verdict = trd_pkg::VD_CSUM;
      end else if ((keys != 8'd0) || (store_i[8][7:4] == 4'd0)) begin
        dec_o.verdict = trd_pkg::VD_RELEASE;
      end else begin
        dec_o.verdict = trd_pkg::VD_PRESS;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/trd_output.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report decoder: result stage
// Clamps and mirrors the point, keeps the held point and drives the result.
// ----------------------------------------------------------------------------
module trd_output (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire trd_pkg::ev_t  ev_i,
  input  wire trd_pkg::dec_t dec_i,
  input  wire logic [11:0]   width_m1_i,
  input  wire logic [11:0]   height_m1_i,
  input  wire logic          invert_x_i,
  input  wire logic          invert_y_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               pressed_o,
  output logic [11:0]        x_pos_o,
  output logic [11:0]        y_pos_o,
  output logic [1:0]         status_o
);

  logic        out_valid_q;
  logic        pressed_q, pressed_d;
  logic [11:0] x_q, x_d, y_q, y_d;
  logic [1:0]  status_q, status_d;
  logic        held_p_q, held_p_d;
  logic [11:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [11:0] x_cl, y_cl, x_fin, y_fin;

  assign adv_o = ev_i.valid && (!out_valid_q || out_ready_i);

  assign x_cl  = (dec_i.x > width_m1_i) ? width_m1_i : dec_i.x;
  assign y_cl  = (dec_i.y > height_m1_i) ? height_m1_i : dec_i.y;
  assign x_fin = invert_x_i ? (width_m1_i - x_cl) : x_cl;
  assign y_fin = invert_y_i ? (height_m1_i - y_cl) : y_cl;

  always_comb begin
    held_p_d  = held_p_q;
    held_x_d  = held_x_q;
    held_y_d  = held_y_q;
    pressed_d = held_p_q;
    x_d       = held_x_q;
    y_d       = held_y_q;
    status_d  = trd_pkg::ST_FRESH;
    unique case (ev_i.code)
      trd_pkg::EV_NOCTRL: begin
        pressed_d = 1'b0;
        x_d       = '0;
        y_d       = '0;
        status_d  = trd_pkg::ST_NOCTRL;
      end
      trd_pkg::EV_BUS: begin
        status_d = trd_pkg::ST_BUS;
      end
      default: begin
        unique case (dec_i.verdict)
          trd_pkg::VD_CSUM: begin
            status_d = trd_pkg::ST_CSUM;
          end
          trd_pkg::VD_PRESS: begin
            held_p_d  = 1'b1;
            held_x_d  = x_fin;
            held_y_d  = y_fin;
            pressed_d = 1'b1;
            x_d       = x_fin;
            y_d       = y_fin;
          end
          default: begin
            held_p_d  = 1'b0;
            pressed_d = 1'b0;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_p_q    <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      if (adv_o) begin
        out_valid_q <= 1'b1;
        held_p_q    <= held_p_d;
        held_x_q    <= held_x_d;
        held_y_q    <= held_y_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pressed_q <= pressed_d;
      x_q       <= x_d;
      y_q       <= y_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pressed_o   = pressed_q;
  assign x_pos_o     = x_q;
  assign y_pos_o     = y_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

// ----- hw/rtl/touch_report_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report decoder
// Turns touch-controller reply bytes into pressed/position results.
// ----------------------------------------------------------------------------
// The block accepts one reply byte (or a bus-failure marker) per clock cycle
// while the input is not stalled, and produces one result per completed
// report, per bus failure, and per item taken while no controller is
// configured. The completing item is stored and posts an event, and the
// result stage then decodes the stored report, clamps and mirrors the point
// and loads the output register. The event register and the output register
// form two stages, so the input only stalls when both are full while the
// result consumer holds ready low. Panel sizes are reduced to their largest
// coordinate as they are written, so a size of zero acts as one and anything
// above 4096 acts as 4096. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module touch_report_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pressed_o,
  output logic [11:0]      x_pos_o,
  output logic [11:0]      y_pos_o,
  output logic [1:0]       status_o
);

  // Largest usable coordinate for a written panel size.
  function automatic logic [11:0] size_to_max(input logic [12:0] v);
    logic [12:0] m;
    begin
      m = v - 13'd1;
      if (v == 13'd0) begin
        m = 13'd0;
      end else if (v > 13'd4096) begin
        m = 13'd4095;
      end
      size_to_max = m[11:0];
    end
  endfunction

  logic [1:0]       kind_q;
  logic [11:0]      width_m1_q, height_m1_q;
  logic             invert_x_q, invert_y_q;
  trd_pkg::ev_t     ev;
  trd_pkg::report_t store;
  trd_pkg::dec_t    dec;
  logic             adv;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= trd_pkg::KIND_NONE;
      width_m1_q  <= 12'd639;
      height_m1_q <= 12'd179;
      invert_x_q  <= 1'b0;
      invert_y_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trd_pkg::REG_KIND:     kind_q      <= cfg_wdata_i[1:0];
        trd_pkg::REG_WIDTH:    width_m1_q  <= size_to_max(cfg_wdata_i);
        trd_pkg::REG_HEIGHT:   height_m1_q <= size_to_max(cfg_wdata_i);
        trd_pkg::REG_INVERT_X: invert_x_q  <= cfg_wdata_i[0];
        trd_pkg::REG_INVERT_Y: invert_y_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: byte capture and report framing.
  trd_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .kind_i      (kind_q),
    .adv_i       (adv),
    .ev_o        (ev),
    .store_o     (store)
  );

  // The decode reads the store while the event waits; the capture stage
  // does not touch the store until the event has moved on.
  trd_decode u_decode (
    .store_i (store),
    .fmt_b_i (ev.code == trd_pkg::EV_DEC_B),
    .dec_o   (dec)
  );

  // Stage two: clamp, mirror, held point and result register.
  trd_output u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .dec_i       (dec),
    .width_m1_i  (width_m1_q),
    .height_m1_i (height_m1_q),
    .invert_x_i  (invert_x_q),
    .invert_y_i  (invert_y_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pressed_o   (pressed_o),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .status_o    (status_o)
  );

  // A pending event with a stalled result must block new items.
  a_block_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.valid && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while both stages are full");

  // A new result is only loaded from a posted event.
  a_result_from_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ev.valid))
    else $error("result appeared without an event");

  // With no controller the result is always a release at the origin.
  a_noctrl_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == trd_pkg::ST_NOCTRL)
    |-> !pressed_o && (x_pos_o == 12'd0) && (y_pos_o == 12'd0))
    else $error("no-controller result is not a release at the origin");

endmodule
`default_nettype wire
